FILE: rtl/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU cache policy package
// Shared types, action codes and constants for the block cache policy core.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Number of cache slots; the slot fields below are sized for it.
  localparam int ENTRIES = 64;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  file_id;
    logic [31:0] block_number;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic        fill_needed;
    logic        writeback_valid;
    logic [9:0]  writeback_file;
    logic [31:0] writeback_block;
    logic [5:0]  writeback_slot;
    logic        last;
    logic [31:0] hits_total;
    logic [31:0] misses_total;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic hit_upd;   // promote the hit cell, age younger ones
    logic install;   // install key in the chosen cell, age all others
    logic evict;     // reserved; the cells do not act on this bit
    logic set_dirty; // mark touched cell dirty
    logic clr_dirty; // clear dirty mark of the flush-selected cell
  } cell_cmd_t;

endpackage

FILE: rtl/lru_block_cache_policy_core.sv
// ----------------------------------------------------------------------------
// LRU block cache policy core
// Fully associative write-back tag and replacement controller built from a
// row of slot cells with a small sequencer.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | in_valid_i/stall_o | in_word_i  (in_word_t)
// out     | out | out_valid_o/stall_i| out_word_o (out_word_t)
//
// An access goes through accept, cell compare, then rank update and word load;
// the update holds while an emitted word waits. A flush scans the slots in
// order, one slot a cycle, and holds while an emitted word waits.
// Reset clears all valid, dirty and rank state and the counters at once.
// The input is stalled while an item is in work or its last word waits.
// ----------------------------------------------------------------------------
module lru_block_cache_policy_core import lru_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int IdxBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntBits = $clog2(ENTRIES + 1);

  state_e state_q, state_d;
  in_word_t req_q;
  logic [IdxBits-1:0] scan_q, scan_d, tgt_q;
  logic found_q, found_d;
  logic [CntBits-1:0] occ_q;
  logic [31:0] hits_q, miss_q;
  logic out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  cell_cmd_t cmd;
  logic [ENTRIES-1:0] valid, dirty, match, fmatch, sel;
  logic [IdxBits-1:0] rank [ENTRIES];
  logic [9:0]  cfile  [ENTRIES];
  logic [31:0] cblock [ENTRIES];

  // Lookup results, registered between lookup and update
  logic hit_q, full_q;
  logic [IdxBits-1:0] lru_q, href_q;
  logic hit_c;
  logic [IdxBits-1:0] hidx_c, free_c, lru_c;

  always_comb begin
    hit_c  = 1'b0;
    hidx_c = '0;
    free_c = '0;
    lru_c  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_c  = 1'b1;
        hidx_c = IdxBits'(i);
      end
      if (!valid[i]) free_c = IdxBits'(i);
      if (valid[i] && rank[i] == IdxBits'(ENTRIES - 1)) lru_c = IdxBits'(i);
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign sel[g] = (tgt_q == IdxBits'(g));
    lru_cell #(.FileBits(10), .BlockBits(32), .RankBits(IdxBits)) u_cell (
      .clk_i, .rst_ni,
      .file_i(req_q.file_id), .block_i(req_q.block_number),
      .cmd_i(cmd), .sel_i(sel[g]), .ref_rank_i(href_q),
      .valid_o(valid[g]), .dirty_o(dirty[g]), .match_o(match[g]),
      .fmatch_o(fmatch[g]), .rank_o(rank[g]),
      .file_o(cfile[g]), .block_o(cblock[g])
    );
  end

  logic out_free;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !out_free;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  logic scan_hit;
  assign scan_hit = fmatch[scan_q] && dirty[scan_q];

  // Next state and cell commands
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    found_d = found_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          if (in_word_i.action == ACT_FLUSH) begin
            state_d = ST_FLUSH;
            scan_d  = '0;
            found_d = 1'b0;
          end else if (in_word_i.action != ACT_NONE) begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          cmd.hit_upd   = hit_q;
          cmd.install   = !hit_q;
          cmd.set_dirty = (req_q.action == ACT_WRITE);
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          cmd.clr_dirty = scan_hit;
          if (scan_hit) found_d = 1'b1;
          if (scan_q == IdxBits'(ENTRIES - 1)) state_d = ST_IDLE;
          else scan_d = scan_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Target index for the cell row
  logic [IdxBits-1:0] tgt_d;
  always_comb begin
    tgt_d = tgt_q;
    case (state_d)
      ST_FLUSH: tgt_d = scan_d;
      ST_UPDATE: begin
        if (state_q == ST_LOOKUP)
          tgt_d = hit_c ? hidx_c : ((occ_q == CntBits'(ENTRIES)) ? lru_c : free_c);
      end
      default: ;
    endcase
  end

  // Any later dirty match in the flush scan
  logic more_dirty;
  always_comb begin
    more_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (IdxBits'(i) > scan_q && fmatch[i] && dirty[i]) more_dirty = 1'b1;
  end

  // Build the next output word; drop an accepted word, hold a stalled one
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (state_q == ST_UPDATE && out_free) begin
      out_valid_d        = 1'b1;
      out_d              = '0;
      out_d.hit          = hit_q;
      out_d.slot         = 6'(tgt_q);
      out_d.fill_needed  = !hit_q;
      out_d.last         = 1'b1;
      out_d.hits_total   = hit_q ? hits_q + 32'd1 : hits_q;
      out_d.misses_total = hit_q ? miss_q : miss_q + 32'd1;
      if (!hit_q && full_q && dirty[lru_q]) begin
        out_d.writeback_valid = 1'b1;
        out_d.writeback_file  = cfile[lru_q];
        out_d.writeback_block = cblock[lru_q];
        out_d.writeback_slot  = 6'(lru_q);
      end
    end
    if (state_q == ST_FLUSH && out_free) begin
      if (scan_hit || (scan_q == IdxBits'(ENTRIES - 1) && !found_q))
        out_valid_d = 1'b1;
      out_d              = '0;
      out_d.hits_total   = hits_q;
      out_d.misses_total = miss_q;
      if (scan_hit) begin
        out_d.writeback_valid = 1'b1;
        out_d.writeback_file  = cfile[scan_q];
        out_d.writeback_block = cblock[scan_q];
        out_d.writeback_slot  = 6'(scan_q);
        out_d.last            = !more_dirty;
      end else begin
        out_d.last = 1'b1;
      end
    end
  end

  // Sequencer and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      tgt_q       <= '0;
      found_q     <= 1'b0;
      occ_q       <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      tgt_q       <= tgt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_UPDATE && out_free) begin
        if (hit_q) hits_q <= hits_q + 32'd1;
        else begin
          miss_q <= miss_q + 32'd1;
          if (!full_q) occ_q <= occ_q + 1'b1;
        end
      end
    end
  end

  // Capture request, lookup results and output word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) req_q <= in_word_i;
    if (state_q == ST_LOOKUP) begin
      hit_q  <= hit_c;
      lru_q  <= lru_c;
      href_q <= rank[hidx_c];
      full_q <= (occ_q == CntBits'(ENTRIES));
    end
    out_q <= out_d;
  end

  // A hit never installs a new key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.hit_upd && cmd.install)) else $error("hit and install together");
  // Occupancy never exceeds slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntBits'(ENTRIES)) else $error("occupancy overflow");
  // Valid cell count tracks occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(valid) == int'(occ_q))
    else $error("occupancy mismatch");

endmodule

FILE: rtl/lru_cell.sv
// ----------------------------------------------------------------------------
// LRU cache slot cell
// Holds one slot: key, valid, dirty and recency rank. Compares its key
// against the broadcast key and ages itself on recency updates.
// ----------------------------------------------------------------------------
module lru_cell import lru_pkg::*; #(
  parameter int FileBits  = 10,
  parameter int BlockBits = 32,
  parameter int RankBits  = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [FileBits-1:0]  file_i,
  input  logic [BlockBits-1:0] block_i,
  input  cell_cmd_t            cmd_i,
  input  logic                 sel_i,      // this cell is the target
  input  logic [RankBits-1:0]  ref_rank_i, // rank of the hit cell
  output logic                 valid_o,
  output logic                 dirty_o,
  output logic                 match_o,
  output logic                 fmatch_o,
  output logic [RankBits-1:0]  rank_o,
  output logic [FileBits-1:0]  file_o,
  output logic [BlockBits-1:0] block_o
);

  logic                 valid_q, dirty_q;
  logic [RankBits-1:0]  rank_q;
  logic [FileBits-1:0]  file_q;
  logic [BlockBits-1:0] block_q;

  assign valid_o  = valid_q;
  assign dirty_o  = dirty_q;
  assign rank_o   = rank_q;
  assign file_o   = file_q;
  assign block_o  = block_q;
  assign fmatch_o = valid_q && (file_q == file_i);
  assign match_o  = fmatch_o && (block_q == block_i);

  // Update control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      if (cmd_i.hit_upd) begin
        if (sel_i) begin
          rank_q <= '0;
          if (cmd_i.set_dirty) dirty_q <= 1'b1;
        end else if (valid_q && rank_q < ref_rank_i) begin
          rank_q <= rank_q + 1'b1;
        end
      end else if (cmd_i.install) begin
        if (sel_i) begin
          valid_q <= 1'b1;
          dirty_q <= cmd_i.set_dirty;
          rank_q  <= '0;
        end else if (valid_q) begin
          rank_q <= rank_q + 1'b1;
        end
      end else if (cmd_i.clr_dirty && sel_i) begin
        dirty_q <= 1'b0;
      end
    end
  end

  // Load key on install
  always_ff @(posedge clk_i) begin
    if (cmd_i.install && sel_i) begin
      file_q  <= file_i;
      block_q <= block_i;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block cache policy core testbench
// Drives read, write, flush and unused actions into the core, predicts each
// output word from a local LRU tag model and checks every field in order.
// ----------------------------------------------------------------------------

class cache_scoreboard;
  localparam int NSLOT = lru_pkg::ENTRIES;

  bit          ent_valid [NSLOT];
  bit [9:0]    ent_file  [NSLOT];
  bit [31:0]   ent_block [NSLOT];
  bit          ent_dirty [NSLOT];
  int unsigned ent_rank  [NSLOT];
  int unsigned occupied;
  bit [31:0]   hit_cnt;
  bit [31:0]   miss_cnt;
  lru_pkg::out_word_t pending_words[$];
  int errors;

  // Add one word to the expected list.
  function void push_word(bit h, bit [5:0] s, bit fl, bit wv, bit [9:0] wf,
                          bit [31:0] wb, bit [5:0] ws, bit lst);
    lru_pkg::out_word_t w;
    w.hit = h; w.slot = s; w.fill_needed = fl; w.writeback_valid = wv;
    w.writeback_file = wf; w.writeback_block = wb; w.writeback_slot = ws;
    w.last = lst; w.hits_total = hit_cnt; w.misses_total = miss_cnt;
    pending_words.push_back(w);
  endfunction

  // Update the tag model for one accepted word and queue its results.
  function void note_input(lru_pkg::in_word_t iw);
    int n;
    int victim;
    int unsigned best;
    int unsigned r;
    bit wv;
    bit [9:0] wf;
    bit [31:0] wb;
    bit [5:0] ws;
    n = 0; victim = 0; best = 0; wv = 0; wf = 0; wb = 0; ws = 0;
    if (iw.action == lru_pkg::ACT_NONE) return;
    if (iw.action == lru_pkg::ACT_FLUSH) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (ent_valid[i] && ent_dirty[i] && ent_file[i] == iw.file_id) begin
          ent_dirty[i] = 0;
          push_word(0, 0, 0, 1, ent_file[i], ent_block[i], i[5:0], 0);
          n++;
        end
      end
      if (n == 0) push_word(0, 0, 0, 0, 0, 0, 0, 1);
      else pending_words[$].last = 1;
      return;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (ent_valid[i] && ent_file[i] == iw.file_id && ent_block[i] == iw.block_number) begin
        r = ent_rank[i];
        for (int k = 0; k < NSLOT; k++)
          if (ent_valid[k] && ent_rank[k] < r) ent_rank[k]++;
        ent_rank[i] = 0;
        if (iw.action == lru_pkg::ACT_WRITE) ent_dirty[i] = 1;
        hit_cnt++;
        push_word(1, i[5:0], 0, 0, 0, 0, 0, 1);
        return;
      end
    end
    miss_cnt++;
    if (occupied >= NSLOT) begin
      for (int k = 0; k < NSLOT; k++)
        if (ent_valid[k] && ent_rank[k] >= best) begin
          best = ent_rank[k];
          victim = k;
        end
      if (ent_dirty[victim]) begin
        wv = 1; wf = ent_file[victim]; wb = ent_block[victim]; ws = victim[5:0];
      end
      ent_valid[victim] = 0;
      occupied--;
    end else begin
      for (int k = NSLOT - 1; k >= 0; k--)
        if (!ent_valid[k]) victim = k;
    end
    for (int k = 0; k < NSLOT; k++)
      if (ent_valid[k]) ent_rank[k]++;
    ent_valid[victim] = 1;
    ent_file[victim] = iw.file_id;
    ent_block[victim] = iw.block_number;
    ent_dirty[victim] = (iw.action == lru_pkg::ACT_WRITE);
    ent_rank[victim] = 0;
    occupied++;
    push_word(0, victim[5:0], 1, wv, wf, wb, ws, 1);
  endfunction

  // Compare one output word with the oldest expectation.
  function void check_output(lru_pkg::out_word_t w);
    lru_pkg::out_word_t e;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected word %h", $time, w);
      errors++;
      return;
    end
    e = pending_words.pop_front();
    if (w !== e) begin
      $display("%0t: mismatch expected %h actual %h", $time, e, w);
      if (w.hit !== e.hit) $display("  hit exp %0d act %0d", e.hit, w.hit);
      if (w.slot !== e.slot) $display("  slot exp %0d act %0d", e.slot, w.slot);
      if (w.writeback_valid !== e.writeback_valid || w.writeback_slot !== e.writeback_slot)
        $display("  wb exp %0d/%0d act %0d/%0d", e.writeback_valid, e.writeback_slot,
                 w.writeback_valid, w.writeback_slot);
      if (w.last !== e.last) $display("  last exp %0d act %0d", e.last, w.last);
      errors++;
    end
  endfunction
endclass

module tb;
  import lru_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  cache_scoreboard sb;
  bit        long_hold;
  bit [31:0] hot_blocks[8];

  lru_block_cache_policy_core dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_word_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_output(out_word_o);
  end

  // Offer one word and hold it until accepted.
  task automatic send_word(action_e act, bit [9:0] fid, bit [31:0] blk);
    in_valid_i <= 1;
    in_word_i  <= '{action: act, file_id: fid, block_number: blk};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int cycles);
    in_valid_i <= 0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Random access, mostly on small key sets (hot blocks, low block numbers) to get hits and evictions.
  task automatic send_random();
    int sel;
    action_e act;
    bit [9:0] fid;
    bit [31:0] blk;
    sel = $urandom_range(0, 99);
    act = (sel < 45) ? ACT_READ : (sel < 88) ? ACT_WRITE : (sel < 97) ? ACT_FLUSH : ACT_NONE;
    fid = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) blk = $urandom;
    else if ($urandom_range(0, 1)) blk = hot_blocks[$urandom_range(0, 7)];
    else blk = $urandom_range(0, 90);
    send_word(act, fid, blk);
  endtask

  // Receiver stall pattern with runs of no stall, random stalls and one long hold-off.
  initial begin
    int mode;
    out_stall_i = 1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1;
        repeat (300) @(negedge clk_i);
        long_hold = 0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 20)) begin
        out_stall_i <= (mode == 0) ? 1'b0 : (mode == 1) ? ($urandom_range(0, 3) == 0)
                                          : ($urandom_range(0, 1) == 0);
        @(negedge clk_i);
      end
    end
  end

  initial begin
    #10ms;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int wait_cycles;
    sb = new();
    long_hold = 0;
    rst_ni = 0;
    in_valid_i = 0;
    in_word_i = '0;
    foreach (hot_blocks[i]) hot_blocks[i] = $urandom;
    hot_blocks[0] = 32'hFFFF_FFFF;
    hot_blocks[1] = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: flush of empty cache, field extremes, hit, unused action.
    send_word(ACT_FLUSH, 10'd0, 32'd0);
    send_word(ACT_READ, 10'd0, 32'd0);
    send_word(ACT_WRITE, 10'h3FF, 32'hFFFF_FFFF);
    send_word(ACT_READ, 10'd0, 32'd0);
    send_word(ACT_NONE, 10'h155, 32'hAAAA_5555);
    send_word(ACT_WRITE, 10'h2AA, 32'h5555_AAAA);
    send_word(ACT_WRITE, 10'h3FF, 32'd7);
    send_word(ACT_FLUSH, 10'h3FF, 32'd0);
    send_word(ACT_FLUSH, 10'h3FF, 32'd0);
    send_word(ACT_FLUSH, 10'h2AA, 32'hFFFF_FFFF);
    // Fill past capacity with dirty entries so evictions write back.
    for (int i = 0; i < 70; i++) send_word(ACT_WRITE, 10'd5, 32'(i));
    send_word(ACT_READ, 10'd5, 32'd69);
    send_word(ACT_FLUSH, 10'd5, 32'd0);

    // Long receiver hold-off while the sender keeps offering.
    long_hold = 1;
    for (int i = 0; i < 30; i++) send_random();

    // Random bursts.
    for (int i = 0; i < 340; i++) begin
      send_random();
      if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 6));
    end
    in_valid_i <= 0;

    wait_cycles = 0;
    while (sb.pending_words.size() != 0 && wait_cycles < 200000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (100) @(negedge clk_i);
    if (sb.pending_words.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, sb.pending_words.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lru_pkg.sv
rtl/lru_cell.sv
rtl/lru_block_cache_policy_core.sv
dv/tb.sv
